@@ rtl/core/spe_pkg.sv @@
// Package for the sparse polynomial evaluator: sizing constants, the sequencer
// state type and the fixed-point rounding and saturation helper.
// Depends on nothing; imported by sparse_polynomial_evaluator and the testbench.
package spe_pkg;

  localparam int TERM_DEPTH = 16;
  localparam int FRAC_BITS  = 16;

  localparam int DATA_W  = 32;
  localparam int POWER_W = 6;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int COUNT_W = 5;
  localparam int BIT_W   = $clog2(POWER_W);
  localparam int IDX_W   = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TERM_DEPTH + 1);
  localparam int ACC_W   = DATA_W + IDX_W + 1;

  localparam logic [PROD_W-1:0] ROUND_CONST = (PROD_W'(1) << FRAC_BITS) >> 1;
  localparam logic [DATA_W-1:0] FX_ONE      = DATA_W'(PROD_W'(1) << FRAC_BITS);
  localparam logic [BIT_W-1:0]  TOP_BIT     = BIT_W'(POWER_W - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQR,
    S_SQR_W,
    S_XMUL,
    S_XMUL_W,
    S_COEF,
    S_COEF_W,
    S_FIN
  } spe_state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     ovf;
  } fx_res_t;

  // Rounds a full product to nearest (ties up), drops the fraction bits with an
  // arithmetic shift and saturates to the data width.
  function automatic fx_res_t fx_round_sat(input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] rounded;
    logic signed [PROD_W-1:0] shifted;
    fx_res_t                  res;
    rounded = prod + $signed(ROUND_CONST);
    shifted = rounded >>> FRAC_BITS;
    if (shifted > $signed({{(PROD_W-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}})) begin
      res.value = {1'b0, {(DATA_W-1){1'b1}}};
      res.ovf   = 1'b1;
    end else if (shifted < $signed({{(PROD_W-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}})) begin
      res.value = {1'b1, {(DATA_W-1){1'b0}}};
      res.ovf   = 1'b1;
    end else begin
      res.value = shifted[DATA_W-1:0];
      res.ovf   = 1'b0;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/sparse_polynomial_evaluator.sv @@
// Top level of the sparse polynomial evaluator: term table, sequencer and the
// shared fixed-point multiplier. Depends on spe_pkg.
//
// The block holds up to TERM_DEPTH terms (coefficient and power 0..63) sorted
// by ascending power. An item is taken when start_i is high and busy_o is low;
// mode_i selects insert (0) or evaluate (1). Every item gives exactly one
// result, shown on the result ports for a single cycle with valid_o high; the
// receiver cannot hold it off, so it must take the result in that cycle. An
// insert is done in the cycle it is accepted: busy_o stays low, the result
// follows in the next cycle and a new item may be accepted meanwhile. An
// evaluate holds busy_o high while one shared 32 x 32 multiplier works
// through the terms one after another. Each multiply registers the product,
// then rounds and saturates it, and x to the power p is built by
// square-and-multiply over all six power bits. The result of an evaluate
// appears in the same cycle in which busy_o falls. There is no clearing pass
// after reset: only entries below the term count are read.
module sparse_polynomial_evaluator
  import spe_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     mode_i,
  input  logic signed [DATA_W-1:0] coefficient_i,
  input  logic [POWER_W-1:0]       power_i,
  input  logic signed [DATA_W-1:0] x_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] value_o,
  output logic                     overflow_o,
  output logic                     table_full_o,
  output logic [COUNT_W-1:0]       count_o
);

  // Term table. Each entry is read at its own fixed place for the insert
  // shift, and at the walking index during evaluation.
  logic signed [DATA_W-1:0] coeff_q [TERM_DEPTH];
  logic signed [DATA_W-1:0] coeff_d [TERM_DEPTH];
  logic [POWER_W-1:0]       power_q [TERM_DEPTH];
  logic [POWER_W-1:0]       power_d [TERM_DEPTH];
  logic [TERM_DEPTH-1:0]    below;

  logic [CNT_W-1:0]         count_q, count_d;
  spe_state_e               state_q, state_d;
  logic [IDX_W-1:0]         k_q, k_d;
  logic [BIT_W-1:0]         bit_q, bit_d;
  logic signed [DATA_W-1:0] r_q, r_d;
  logic signed [DATA_W-1:0] x_q, x_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     ovf_q, ovf_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  logic                     valid_q, valid_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic                     overflow_q, overflow_d;
  logic                     full_q, full_d;

  logic                     accept;
  logic                     table_is_full;
  logic                     last_term;
  logic                     cur_bit;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  fx_res_t                  fx;

  assign accept        = start_i && !busy_o;
  assign table_is_full = (count_q == CNT_W'(TERM_DEPTH));
  assign last_term     = (CNT_W'(k_q) + CNT_W'(1)) == count_q;
  assign cur_bit       = power_q[k_q][bit_q];
  assign fx            = fx_round_sat(prod_q);

  // An entry takes part in the insert search only if it holds a live term.
  always_comb begin
    for (int i = 0; i < TERM_DEPTH; i++) begin
      below[i] = (CNT_W'(i) < count_q) && (power_q[i] < power_i);
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && mode_i) begin
          state_d = (count_q == '0) ? S_FIN : S_SQR;
        end
      end
      S_SQR:    state_d = S_SQR_W;
      S_SQR_W: begin
        if (cur_bit) begin
          state_d = S_XMUL;
        end else if (bit_q == '0) begin
          state_d = S_COEF;
        end else begin
          state_d = S_SQR;
        end
      end
      S_XMUL:   state_d = S_XMUL_W;
      S_XMUL_W: state_d = (bit_q == '0) ? S_COEF : S_SQR;
      S_COEF:   state_d = S_COEF_W;
      S_COEF_W: state_d = last_term ? S_FIN : S_SQR;
      S_FIN:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = r_q;
    mul_b = r_q;
    case (state_q)
      S_XMUL:  mul_b = x_q;
      S_COEF:  mul_a = coeff_q[k_q];
      default: mul_b = r_q;
    endcase
    prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Datapath and result registers.
  always_comb begin
    count_d    = count_q;
    k_d        = k_q;
    bit_d      = bit_q;
    r_d        = r_q;
    x_d        = x_q;
    acc_d      = acc_q;
    ovf_d      = ovf_q;
    valid_d    = 1'b0;
    value_d    = value_q;
    overflow_d = overflow_q;
    full_d     = full_q;
    coeff_d    = coeff_q;
    power_d    = power_q;

    case (state_q)
      S_IDLE: begin
        if (accept && !mode_i) begin
          // Insert: finished here, result shown in the next cycle.
          valid_d    = 1'b1;
          value_d    = '0;
          overflow_d = 1'b0;
          full_d     = table_is_full;
          if (!table_is_full) begin
            for (int i = 0; i < TERM_DEPTH; i++) begin
              if (CNT_W'(i) <= count_q && !below[i]) begin
                if (i == 0 || below[(i > 0) ? i - 1 : 0]) begin
                  coeff_d[i] = coefficient_i;
                  power_d[i] = power_i;
                end else begin
                  coeff_d[i] = coeff_q[(i > 0) ? i - 1 : 0];
                  power_d[i] = power_q[(i > 0) ? i - 1 : 0];
                end
              end
            end
            count_d = count_q + CNT_W'(1);
          end
        end else if (accept) begin
          x_d   = x_i;
          k_d   = '0;
          bit_d = TOP_BIT;
          r_d   = FX_ONE;
          acc_d = '0;
          ovf_d = 1'b0;
        end
      end
      S_SQR_W: begin
        r_d   = fx.value;
        ovf_d = ovf_q | fx.ovf;
        if (!cur_bit && bit_q != '0) begin
          bit_d = bit_q - BIT_W'(1);
        end
      end
      S_XMUL_W: begin
        r_d   = fx.value;
        ovf_d = ovf_q | fx.ovf;
        if (bit_q != '0) begin
          bit_d = bit_q - BIT_W'(1);
        end
      end
      S_COEF_W: begin
        acc_d = acc_q + ACC_W'(fx.value);
        ovf_d = ovf_q | fx.ovf;
        k_d   = k_q + IDX_W'(1);
        bit_d = TOP_BIT;
        r_d   = FX_ONE;
      end
      S_FIN: begin
        // The sum is saturated once, at the end.
        valid_d = 1'b1;
        full_d  = 1'b0;
        if (acc_q > ACC_W'($signed({1'b0, {(DATA_W-1){1'b1}}}))) begin
          value_d    = {1'b0, {(DATA_W-1){1'b1}}};
          overflow_d = 1'b1;
        end else if (acc_q < ACC_W'($signed({1'b1, {(DATA_W-1){1'b0}}}))) begin
          value_d    = {1'b1, {(DATA_W-1){1'b0}}};
          overflow_d = 1'b1;
        end else begin
          value_d    = acc_q[DATA_W-1:0];
          overflow_d = ovf_q;
        end
      end
      default: begin
        ovf_d = ovf_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coeff_q    <= coeff_d;
    power_q    <= power_d;
    k_q        <= k_d;
    bit_q      <= bit_d;
    r_q        <= r_d;
    x_q        <= x_d;
    acc_q      <= acc_d;
    ovf_q      <= ovf_d;
    prod_q     <= prod_d;
    value_q    <= value_d;
    overflow_q <= overflow_d;
    full_q     <= full_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign valid_o      = valid_q;
  assign value_o      = value_q;
  assign overflow_o   = overflow_q;
  assign table_full_o = full_q;
  assign count_o      = COUNT_W'(count_q);

endmodule

@@ tb/sparse_polynomial_evaluator_checker.sv @@
`timescale 1ns / 1ps
// Mode codes shared by the testbench, and a checker that predicts and compares
// every result of the sparse polynomial evaluator. Depends on spe_pkg.
package spe_tb_pkg;

  typedef enum logic {
    MODE_INSERT   = 1'b0,
    MODE_EVALUATE = 1'b1
  } spe_mode_e;

endpackage

module sparse_polynomial_evaluator_checker
  import spe_pkg::*;
  import spe_tb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic                     mode_i,
  input  logic signed [DATA_W-1:0] coefficient_i,
  input  logic [POWER_W-1:0]       power_i,
  input  logic signed [DATA_W-1:0] x_i,
  input  logic                     valid_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     overflow_i,
  input  logic                     table_full_i,
  input  logic [COUNT_W-1:0]       count_i,
  output int                       errors_o,
  output int                       pending_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     overflow;
    logic                     table_full;
    logic [COUNT_W-1:0]       count;
  } poly_result_t;

  localparam longint FX_MAX = (longint'(1) << (DATA_W - 1)) - 1;
  localparam longint FX_MIN = -(longint'(1) << (DATA_W - 1));

  logic signed [DATA_W-1:0] coeff_tab [TERM_DEPTH];
  logic [POWER_W-1:0]       power_tab [TERM_DEPTH];
  int                       stored_terms;
  bit                       clipped;
  poly_result_t             awaited_q [$];

  // Clamps to the data range and notes any clamping for the current evaluation.
  function automatic logic signed [DATA_W-1:0] clip(input longint v);
    if (v > FX_MAX) begin
      clipped = 1'b1;
      return DATA_W'(FX_MAX);
    end
    if (v < FX_MIN) begin
      clipped = 1'b1;
      return DATA_W'(FX_MIN);
    end
    return DATA_W'(v);
  endfunction

  // Rounds half up, then floors away the fraction bits.
  function automatic logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    longint full;
    full = longint'(a) * longint'(b) + ((longint'(1) << FRAC_BITS) >>> 1);
    return clip(full >>> FRAC_BITS);
  endfunction

  function automatic logic signed [DATA_W-1:0] raise(input logic signed [DATA_W-1:0] x,
                                                     input logic [POWER_W-1:0] p);
    logic signed [DATA_W-1:0] r;
    r = FX_ONE;
    for (int b = POWER_W - 1; b >= 0; b--) begin
      r = fx_mul(r, r);
      if (p[b]) begin
        r = fx_mul(r, x);
      end
    end
    return r;
  endfunction

  function automatic poly_result_t evaluate_at(input logic signed [DATA_W-1:0] x);
    longint       total;
    poly_result_t r;
    clipped = 1'b0;
    total   = 0;
    for (int k = 0; k < stored_terms; k++) begin
      total += longint'(fx_mul(coeff_tab[k], raise(x, power_tab[k])));
    end
    r.value      = clip(total);
    r.overflow   = clipped;
    r.table_full = 1'b0;
    r.count      = COUNT_W'(stored_terms);
    return r;
  endfunction

  // Equal powers go in front of the terms already stored with that power.
  function automatic poly_result_t insert_term(input logic signed [DATA_W-1:0] coef,
                                               input logic [POWER_W-1:0] pwr);
    int           slot;
    poly_result_t r;
    r.value      = '0;
    r.overflow   = 1'b0;
    r.table_full = 1'b0;
    if (stored_terms >= TERM_DEPTH) begin
      r.table_full = 1'b1;
    end else begin
      slot = 0;
      while (slot < stored_terms && power_tab[slot] < pwr) begin
        slot++;
      end
      for (int k = stored_terms; k > slot; k--) begin
        coeff_tab[k] = coeff_tab[k-1];
        power_tab[k] = power_tab[k-1];
      end
      coeff_tab[slot] = coef;
      power_tab[slot] = pwr;
      stored_terms++;
    end
    r.count = COUNT_W'(stored_terms);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors_o++;
    end
  endtask

  // A result is compared before the item accepted at the same edge is
  // predicted: no item can show its result at the edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin : track
    poly_result_t want;
    if (!rst_ni) begin
      stored_terms = 0;
      awaited_q.delete();
      pending_o = 0;
    end else begin
      if (valid_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %h count %0d",
                   $time, value_i, count_i);
          errors_o++;
        end else begin
          want = awaited_q.pop_front();
          compare_field("value", want.value, value_i);
          compare_field("overflow", DATA_W'(want.overflow), DATA_W'(overflow_i));
          compare_field("table_full", DATA_W'(want.table_full), DATA_W'(table_full_i));
          compare_field("count", DATA_W'(want.count), DATA_W'(count_i));
        end
      end
      if (start_i && !busy_i) begin
        if (mode_i == MODE_EVALUATE) begin
          awaited_q.push_back(evaluate_at(x_i));
        end else begin
          awaited_q.push_back(insert_term(coefficient_i, power_i));
        end
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

@@ tb/sparse_polynomial_evaluator_test.sv @@
`timescale 1ns / 1ps
// Top of the sparse polynomial evaluator testbench: clock, reset, item stimulus,
// watchdog and verdict. Depends on spe_pkg and sparse_polynomial_evaluator_checker.
module sparse_polynomial_evaluator_test;

  import spe_pkg::*;
  import spe_tb_pkg::*;

  // The limit lies well beyond the time for which the slowest evaluate keeps
  // busy_o high, so a quiet stretch that long means the block has hung.
  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_ITEMS = 575;
  localparam int CALM_ITEMS   = 100;
  localparam int DRAIN_CYCLES = 450;
  localparam int FILL_COUNT   = 13;

  // Powers used to fill the table in the directed part. They arrive out of
  // order, repeat the extremes and so exercise the sorted insertion.
  localparam logic [POWER_W-1:0] FILL_POWERS [FILL_COUNT] =
    '{6'd32, 6'd1, 6'd62, 6'd63, 6'd2, 6'd0, 6'd31, 6'd15, 6'd7, 6'd48, 6'd5, 6'd33, 6'd20};

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic                     mode_i;
  logic signed [DATA_W-1:0] coefficient_i;
  logic [POWER_W-1:0]       power_i;
  logic signed [DATA_W-1:0] x_i;
  logic                     valid_o;
  logic signed [DATA_W-1:0] value_o;
  logic                     overflow_o;
  logic                     table_full_o;
  logic [COUNT_W-1:0]       count_o;

  int errors;
  int pending;
  bit gaps_enabled;

  sparse_polynomial_evaluator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .coefficient_i (coefficient_i),
    .power_i       (power_i),
    .x_i           (x_i),
    .valid_o       (valid_o),
    .value_o       (value_o),
    .overflow_o    (overflow_o),
    .table_full_o  (table_full_o),
    .count_o       (count_o)
  );

  sparse_polynomial_evaluator_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .mode_i        (mode_i),
    .coefficient_i (coefficient_i),
    .power_i       (power_i),
    .x_i           (x_i),
    .valid_i       (valid_o),
    .value_i       (value_o),
    .overflow_i    (overflow_o),
    .table_full_i  (table_full_o),
    .count_i       (count_o),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A fixed-point value: a full-range random word, a value within plus or
  // minus span, or one of the corner values (the two extremes, zero, +1, -1).
  function automatic logic [DATA_W-1:0] rand_fixed(input int span);
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2, 3: return DATA_W'(int'($urandom_range(0, 2 * span)) - span);
      default: begin
        case ($urandom_range(0, 4))
          0: return {1'b0, {(DATA_W-1){1'b1}}};
          1: return {1'b1, {(DATA_W-1){1'b0}}};
          2: return '0;
          3: return FX_ONE;
          default: return -FX_ONE;
        endcase
      end
    endcase
  endfunction

  // Quiet the sender for the given number of cycles. Start is lowered at a
  // falling edge and the next item raises it again at a later falling edge
  // at the earliest, so the two assignments never share a time step.
  task automatic hold_off(input int cycles);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Present one item and hold it until the block takes it. busy_o is sampled
  // at the rising edge, before the block updates it, so the edge at which it
  // reads low is the edge that accepts the item.
  task automatic issue(input spe_mode_e mode, input logic [DATA_W-1:0] coef,
                       input logic [POWER_W-1:0] pwr, input logic [DATA_W-1:0] xval);
    @(negedge clk_i);
    start_i       <= 1'b1;
    mode_i        <= mode;
    coefficient_i <= coef;
    power_i       <= pwr;
    x_i           <= xval;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (gaps_enabled && $urandom_range(0, 1)) begin
      hold_off($urandom_range(1, 7));
    end
  endtask

  // Stop sending and wait for every outstanding result. The checker updates
  // its count at rising edges, so it is read at falling edges.
  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    start_i       = 1'b0;
    mode_i        = MODE_INSERT;
    coefficient_i = '0;
    power_i       = '0;
    x_i           = '0;
    rst_ni        = 1'b0;
    gaps_enabled  = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    gaps_enabled = 1'($urandom_range(0, 1));

    // Directed part. An evaluate on the empty table must give zero without
    // overflow, even at the largest x.
    issue(MODE_EVALUATE, '0, '0, {1'b0, {(DATA_W-1){1'b1}}});
    // The extreme coefficients at the extreme powers, and a second term of
    // power zero to check that equal powers are kept apart.
    issue(MODE_INSERT, {1'b0, {(DATA_W-1){1'b1}}}, 6'd63, '0);
    issue(MODE_INSERT, {1'b1, {(DATA_W-1){1'b0}}}, 6'd0, '0);
    issue(MODE_INSERT, FX_ONE, 6'd0, '0);
    // x of zero still gives x to the power zero as exactly one; plus and minus
    // one, the most negative x (which saturates) and one half follow.
    issue(MODE_EVALUATE, '0, '0, '0);
    issue(MODE_EVALUATE, '0, '0, FX_ONE);
    issue(MODE_EVALUATE, '0, '0, -FX_ONE);
    issue(MODE_EVALUATE, '0, '0, {1'b1, {(DATA_W-1){1'b0}}});
    issue(MODE_EVALUATE, '0, '0, FX_ONE >> 1);
    // Fill the rest of the table with random coefficients.
    for (int k = 0; k < FILL_COUNT; k++) begin
      issue(MODE_INSERT, rand_fixed(4 * int'(FX_ONE)), FILL_POWERS[k], '0);
    end
    // The table is full now, so this insert must be refused and flagged.
    issue(MODE_INSERT, rand_fixed(4 * int'(FX_ONE)), 6'd10, '0);
    issue(MODE_EVALUATE, '0, '0, -(FX_ONE >> 1));
    issue(MODE_EVALUATE, '0, '0, FX_ONE + 1);
    drain_results();

    // Random part. The table cannot be emptied without a reset, so from here
    // on inserts are refused and evaluates explore x over the full table.
    // Unused fields carry random bits as well. Idling is switched on and off
    // in stretches and stays off towards the end.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
        gaps_enabled = 1'b0;
      end else if (n % 50 == 0) begin
        gaps_enabled = 1'($urandom_range(0, 1));
      end
      if (n == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      if ($urandom_range(0, 99) < 20) begin
        issue(MODE_INSERT, rand_fixed(4 * int'(FX_ONE)), POWER_W'($urandom_range(0, 63)),
              $urandom);
      end else begin
        issue(MODE_EVALUATE, $urandom, POWER_W'($urandom_range(0, 63)),
              rand_fixed(2 * int'(FX_ONE)));
      end
    end

    // Wait for the last results, then leave time for any stray one to show.
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: counts cycles in which neither an item nor a result moves.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start_i && !busy_o) || valid_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: timeout, nothing accepted for %0d cycles", $time, IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

endmodule
